FILE: design/hcar_pkg.sv
package hcar_pkg;

  localparam int CELL_INDEX_BITS = 20;
  localparam int OUT_INDEX_BITS = 20;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int DOT_BITS = 42;
  localparam int NSQ_BITS = 49;
  localparam int PROD_BITS = 192;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GDX = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GDY = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GDZ = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LDX = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LDY = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LDZ = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NSQ,
    ST_DOT,
    ST_DSQ,
    ST_LHS,
    ST_BSQ,
    ST_RHS,
    ST_CMP,
    ST_FIN_A,
    ST_FIN_B,
    ST_FIN_C,
    ST_OUT
  } state_t;

  // One pass of the shared multiplier: 32x32 unsigned partial product.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_op_t;

endpackage

FILE: design/hcar_mul.sv
// Shared unsigned 32x32 multiplier with a registered product.
module hcar_mul
  import hcar_pkg::*;
(
  input  logic        clk,
  input  mul_op_t     op,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(op.a) * 64'(op.b);
  end

  assign prod = prod_r;

endmodule

FILE: design/hex_cell_aspect_ratio_select.sv
// Sequence per accepted face: the squared norm, then per direction either a skip
// or first-kept check or the exact cross test, and after the last face the ratio
// test; the one 32x32 multiplier is reused.
// Throughput: one face at a time; in_stall stays high until the face is done and
// its result (if any) has been taken.
// Reset: synchronous active-low; best-face state, volume flag, cell counter and
// registers return to their reset values.
module hex_cell_aspect_ratio_select
  import hcar_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [23:0]          in_area_x,
  input  logic signed [23:0]          in_area_y,
  input  logic signed [23:0]          in_area_z,
  input  logic [31:0]                 in_cell_volume,
  input  logic                        in_last_face,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [OUT_INDEX_BITS-1:0]   out_cell_index,
  output logic                        out_selected,
  output logic                        out_no_aligned_face,
  input  logic                        cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

  // Generic wide product: a (up to 96 bits) times b (up to 64 bits) is built
  // from 32-bit limbs, one partial product at a time into an accumulator, in
  // one pass of 3x2 limbs.

  state_t state_r, state_nxt;

  logic signed [15:0] dir_r [6];
  logic [23:0] ratio_r;

  logic [DOT_BITS-1:0] bdot_r [2];
  logic [NSQ_BITS-1:0] bnsq_r [2];
  logic                volnz_r;
  logic [CELL_INDEX_BITS-1:0] cnt_r;

  // face latch
  logic [23:0] ax_r [3];
  logic        last_r;

  logic [NSQ_BITS-1:0] nsq_r;
  logic [DOT_BITS-1:0] dabs_r;
  logic                side_r;
  logic [PROD_BITS-1:0] lhs_r, acc_r;
  logic [95:0] opa_r;
  logic [63:0] opb_r;
  logic [1:0] ia_r, ib_r;
  logic [1:0] comp_r;
  logic       mphase_r;
  logic       lhs_done_r;
  logic       out_v_r, out_sel_r, out_none_r;
  logic [CELL_INDEX_BITS-1:0] out_idx_r;
  logic signed [DOT_BITS+1:0] dot_r;

  mul_op_t     mop;
  logic [63:0] mprod;

  hcar_mul u_mul (.clk(clk), .op(mop), .prod(mprod));

  // Operand magnitude helpers for dot term: |a_i| and |d_i| with sign.
  logic [23:0] amag;
  logic [15:0] dmag;
  logic        tneg;
  logic signed [23:0] asel;
  logic signed [15:0] dsel;
  logic [2:0]  didx;

  always_comb begin
    didx = side_r ? (3'(comp_r) + 3'd3) : 3'(comp_r);
    asel = ax_r[comp_r];
    dsel = dir_r[didx];
    amag = asel[23] ? 24'(-asel) : asel;
    dmag = dsel[15] ? 16'(-dsel) : dsel;
    tneg = asel[23] ^ dsel[15];
  end

  logic [31:0] limb_a, limb_b;
  always_comb begin
    limb_a = opa_r[ia_r*32 +: 32];
    limb_b = opb_r[ib_r*32 +: 32];
    mop.a = limb_a;
    mop.b = limb_b;
    if (state_r == ST_NSQ) begin
      mop.a = 32'(amag);
      mop.b = 32'(amag);
    end else if (state_r == ST_DOT) begin
      mop.a = 32'(amag);
      mop.b = 32'(dmag);
    end
  end

  logic [PROD_BITS-1:0] shifted;
  always_comb begin
    shifted = PROD_BITS'(mprod) << (({6'd0, ia_r} + {6'd0, ib_r}) * 32);
  end

  logic [PROD_BITS-1:0] acc_sum;
  logic                 pass_end;
  assign acc_sum = acc_r + shifted;
  assign pass_end = mphase_r && ib_r == 2'd1 && ia_r == 2'd2;

  logic [NSQ_BITS-1:0] nsq_sum;
  logic signed [DOT_BITS+1:0] dot_sum;
  logic [DOT_BITS+1:0] dot_abs;
  assign nsq_sum = nsq_r + NSQ_BITS'(mprod);
  assign dot_sum = tneg ? dot_r - (DOT_BITS+2)'(mprod) : dot_r + (DOT_BITS+2)'(mprod);
  assign dot_abs = dot_r[DOT_BITS+1] ? (DOT_BITS+2)'(-dot_r) : dot_r;

  assign in_stall = (state_r != ST_IDLE) || out_v_r;
  assign out_valid = out_v_r;
  assign out_cell_index = OUT_INDEX_BITS'(out_idx_r);
  assign out_selected = out_sel_r;
  assign out_no_aligned_face = out_none_r;

  // Sequencer: mphase_r marks the cycle waiting on the registered product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dir_r[0] <= 16'sd32767; dir_r[1] <= '0; dir_r[2] <= '0;
      dir_r[3] <= '0; dir_r[4] <= 16'sd32767; dir_r[5] <= '0;
      ratio_r <= 24'd65536;
      bdot_r[0] <= '0; bdot_r[1] <= '0;
      bnsq_r[0] <= '0; bnsq_r[1] <= '0;
      volnz_r <= 1'b0;
      cnt_r <= '0;
      out_v_r <= 1'b0;
      mphase_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GDX:   dir_r[0] <= cfg_data[15:0];
          REG_GDY:   dir_r[1] <= cfg_data[15:0];
          REG_GDZ:   dir_r[2] <= cfg_data[15:0];
          REG_LDX:   dir_r[3] <= cfg_data[15:0];
          REG_LDY:   dir_r[4] <= cfg_data[15:0];
          REG_LDZ:   dir_r[5] <= cfg_data[15:0];
          REG_RATIO: ratio_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_v_r && !out_stall) out_v_r <= 1'b0;
      state_r <= state_nxt;
      mphase_r <= !mphase_r && (state_r inside {ST_NSQ, ST_DOT, ST_LHS, ST_BSQ, ST_RHS,
                                                ST_FIN_A, ST_FIN_B});
      case (state_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            ax_r[0] <= in_area_x; ax_r[1] <= in_area_y; ax_r[2] <= in_area_z;
            last_r <= in_last_face;
            if (in_cell_volume != 0) volnz_r <= 1'b1;
            nsq_r <= '0; comp_r <= '0; side_r <= 1'b0;
          end
        end
        ST_NSQ: begin
          // Issue one square per component, accumulate the product in the following cycle.
          if (mphase_r) begin
            nsq_r <= nsq_sum;
            if (comp_r == 2'd2) begin comp_r <= '0; dot_r <= '0; end
            else comp_r <= comp_r + 2'd1;
          end
        end
        ST_DOT: begin
          if (mphase_r) begin
            dot_r <= dot_sum;
            if (comp_r == 2'd2) comp_r <= '0;
            else comp_r <= comp_r + 2'd1;
          end
        end
        ST_DSQ: begin
          // d^2 * bn: set up operands d*d first.
          dabs_r <= DOT_BITS'(dot_abs);
          opa_r <= 96'(dot_abs); opb_r <= 64'(dot_abs);
          ia_r <= '0; ib_r <= '0; acc_r <= '0; lhs_done_r <= 1'b0;
        end
        ST_LHS, ST_BSQ, ST_RHS, ST_FIN_A, ST_FIN_B: begin
          if (mphase_r) begin
            acc_r <= pass_end ? '0 : acc_sum;
            if (ib_r == 2'd1) begin
              ib_r <= '0;
              if (ia_r == 2'd2) ia_r <= '0;
              else ia_r <= ia_r + 2'd1;
            end else ib_r <= ib_r + 2'd1;
            if (pass_end) begin
              // pass done: chain into the next product
              case (state_r)
                ST_LHS: begin
                  if (!lhs_done_r) begin
                    opa_r <= acc_sum[95:0];
                    opb_r <= 64'(bnsq_r[side_r]);
                    lhs_done_r <= 1'b1;
                  end else begin
                    lhs_r <= acc_sum;
                    opa_r <= 96'(bdot_r[side_r]); opb_r <= 64'(bdot_r[side_r]);
                  end
                end
                ST_BSQ: begin
                  opa_r <= acc_sum[95:0];
                  opb_r <= 64'(nsq_r);
                end
                ST_RHS: begin
                  // strictly better alignment replaces the kept face
                  if (lhs_r > acc_sum) begin
                    bdot_r[side_r] <= dabs_r; bnsq_r[side_r] <= nsq_r;
                  end
                end
                ST_FIN_A: begin
                  opa_r <= acc_sum[95:0];
                  opb_r <= 64'(bnsq_r[0]);
                end
                ST_FIN_B: lhs_r <= acc_sum;
                default: ;
              endcase
            end
          end
        end
        ST_CMP: begin
          if (dot_r != 0 && bdot_r[side_r] == 0) begin
            bdot_r[side_r] <= DOT_BITS'(dot_abs); bnsq_r[side_r] <= nsq_r;
          end
          comp_r <= '0; dot_r <= '0;
          if (!side_r) side_r <= 1'b1;
          if (last_r && side_r) begin
            opa_r <= 96'(ratio_r); opb_r <= 64'(ratio_r);
            ia_r <= '0; ib_r <= '0; acc_r <= '0;
          end
        end
        ST_FIN_C: begin
          out_v_r <= 1'b1;
          out_idx_r <= cnt_r;
          out_none_r <= (bdot_r[0] == 0) || (bdot_r[1] == 0);
          out_sel_r <= (bdot_r[0] != 0) && (bdot_r[1] != 0) && volnz_r &&
                       ((PROD_BITS'(bnsq_r[1]) << 32) > lhs_r);
          cnt_r <= cnt_r + 1'b1;
          bdot_r[0] <= '0; bdot_r[1] <= '0;
          bnsq_r[0] <= '0; bnsq_r[1] <= '0;
          volnz_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid && !in_stall) state_nxt = ST_NSQ;
      ST_NSQ:   if (mphase_r && comp_r == 2'd2) state_nxt = ST_DOT;
      ST_DOT:   if (mphase_r && comp_r == 2'd2) begin
        // zero-area faces and orthogonal faces are skipped, and a direction's first face is kept without the cross test
        if (nsq_r == 0 || dot_sum == 0 || bdot_r[side_r] == 0) state_nxt = ST_CMP;
        else state_nxt = ST_DSQ;
      end
      ST_DSQ:   state_nxt = ST_LHS;
      ST_LHS:   if (pass_end && lhs_done_r) state_nxt = ST_BSQ;
      ST_BSQ:   if (pass_end) state_nxt = ST_RHS;
      ST_RHS:   if (pass_end) state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (!side_r) state_nxt = ST_DOT;
        else if (last_r) state_nxt = ST_FIN_A;
        else state_nxt = ST_IDLE;
      end
      ST_FIN_A: if (pass_end) state_nxt = ST_FIN_B;
      ST_FIN_B: if (pass_end) state_nxt = ST_FIN_C;
      ST_FIN_C: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

endmodule
